// ----- hw/rtl/cnms_pkg.sv -----
// cnms_pkg: shared types, constants and calendar helpers for the cron next-match search.
// Used by cnms_ctrl, cnms_dp and cron_next_match_search. No dependencies.
package cnms_pkg;

    localparam int SEARCH_YEARS = 5;
    localparam int CFG_W        = 60;
    localparam int YR_W         = 13;

    localparam logic [2:0] REG_MINUTE   = 3'd0;
    localparam logic [2:0] REG_HOUR     = 3'd1;
    localparam logic [2:0] REG_DAY      = 3'd2;
    localparam logic [2:0] REG_MONTH    = 3'd3;
    localparam logic [2:0] REG_WEEKDAY  = 3'd4;
    localparam logic [2:0] REG_DAY_LIM  = 3'd5;
    localparam logic [2:0] REG_WDAY_LIM = 3'd6;

    typedef struct packed {
        logic [11:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [4:0]  start_hour;
        logic [5:0]  start_minute;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [11:0] next_year;
        logic [3:0]  next_month;
        logic [4:0]  next_day;
        logic [4:0]  next_hour;
        logic [5:0]  next_minute;
        logic [2:0]  next_weekday;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic adv;
        logic wd1;
        logic wd2;
        logic wd3;
        logic step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic over;
        logic out_busy;
    } sts_t;

    typedef logic [4:0] mdays_t [12];
    localparam mdays_t MONTH_DAYS = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    typedef logic [2:0] sak_t [12];
    localparam sak_t SAK = '{3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3,
                             3'd5, 3'd1, 3'd4, 3'd6, 3'd2, 3'd4};

    // floor(y/100) by reciprocal, exact for y below 43699
    function automatic logic [6:0] div100(input logic [YR_W-1:0] y);
        logic [25:0] p;
        p = {13'd0, y} * 26'd5243;
        return p[25:19];
    endfunction

    function automatic logic is_leap(input logic [YR_W-1:0] y);
        logic [6:0]      q;
        logic [YR_W-1:0] r;
        q = div100(y);
        r = y - YR_W'({6'd0, q} * 13'd100);
        return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [YR_W-1:0] y,
                                             input logic [3:0] m);
        logic [4:0] n;
        n = MONTH_DAYS[m - 4'd1];
        if (m == 4'd2 && is_leap(y)) n = 5'd29;
        return n;
    endfunction

    function automatic logic [5:0] first60(input logic [59:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 59; i >= 0; i--) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    function automatic logic [4:0] first24(input logic [23:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 23; i >= 0; i--) begin
            if (v[i]) idx = 5'(i);
        end
        return idx;
    endfunction

endpackage

// ----- hw/rtl/cnms_dp.sv -----
// cnms_dp: configuration masks, calendar cursor, weekday setup, day match and result register.
// Depends on cnms_pkg; driven by cnms_ctrl through cnms_pkg::cmd_t.
module cnms_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [2:0]                     cfg_index,
    input  logic [cnms_pkg::CFG_W-1:0]     cfg_data,
    input  cnms_pkg::req_t                 s_req,
    input  cnms_pkg::cmd_t                 cmd,
    output cnms_pkg::sts_t                 sts,
    input  logic                           m_ready,
    output logic                           m_valid,
    output cnms_pkg::rsp_t                 m_rsp
);

    logic [59:0] minute_mask_reg;
    logic [23:0] hour_mask_reg;
    logic [30:0] day_mask_reg;
    logic [11:0] month_mask_reg;
    logic [6:0]  weekday_mask_reg;
    logic        day_lim_reg;
    logic        wday_lim_reg;

    logic [cnms_pkg::YR_W-1:0] yr_reg, maxy_reg, yy_reg;
    logic [3:0]  mo_reg;
    logic [4:0]  d_reg, h_reg;
    logic [5:0]  m_reg;
    logic [6:0]  q100_reg;
    logic [12:0] sum_reg;
    logic [2:0]  wd_reg;
    logic        m_valid_reg;
    cnms_pkg::rsp_t rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minute_mask_reg  <= 60'hFFF_FFFF_FFFF_FFFF;
            hour_mask_reg    <= 24'hFF_FFFF;
            day_mask_reg     <= 31'h7FFF_FFFF;
            month_mask_reg   <= 12'hFFF;
            weekday_mask_reg <= 7'h7F;
            day_lim_reg      <= 1'b0;
            wday_lim_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cnms_pkg::REG_MINUTE:   minute_mask_reg  <= cfg_data[59:0];
                cnms_pkg::REG_HOUR:     hour_mask_reg    <= cfg_data[23:0];
                cnms_pkg::REG_DAY:      day_mask_reg     <= cfg_data[30:0];
                cnms_pkg::REG_MONTH:    month_mask_reg   <= cfg_data[11:0];
                cnms_pkg::REG_WEEKDAY:  weekday_mask_reg <= cfg_data[6:0];
                cnms_pkg::REG_DAY_LIM:  day_lim_reg      <= cfg_data[0];
                cnms_pkg::REG_WDAY_LIM: wday_lim_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp the request
    logic [cnms_pkg::YR_W-1:0] in_yr;
    logic [3:0] in_mo;
    logic [4:0] in_dim, in_d, in_h;
    logic [5:0] in_m;
    always_comb begin
        in_yr = {1'b0, s_req.start_year};
        in_mo = s_req.start_month;
        if (in_mo < 4'd1) in_mo = 4'd1;
        if (in_mo > 4'd12) in_mo = 4'd12;
        in_dim = cnms_pkg::month_len(in_yr, in_mo);
        in_d = s_req.start_day;
        if (in_d < 5'd1) in_d = 5'd1;
        if (in_d > in_dim) in_d = in_dim;
        in_h = (s_req.start_hour > 5'd23) ? 5'd23 : s_req.start_hour;
        in_m = (s_req.start_minute > 6'd59) ? 6'd59 : s_req.start_minute;
    end

    logic [4:0] cur_dim;
    assign cur_dim = cnms_pkg::month_len(yr_reg, mo_reg);

    // day-level match and first minute in the day
    logic        dom_ok, dow_ok, day_ok, mo_ok;
    logic [59:0] mm_ge;
    logic [23:0] hm_gt;
    logic        h0_ok, hgt_ok, hit;
    logic [4:0]  hit_h;
    logic [5:0]  hit_m;
    always_comb begin
        dom_ok = day_mask_reg[d_reg - 5'd1];
        dow_ok = weekday_mask_reg[wd_reg];
        unique case ({day_lim_reg, wday_lim_reg})
            2'b00:   day_ok = 1'b1;
            2'b01:   day_ok = dow_ok;
            2'b10:   day_ok = dom_ok;
            default: day_ok = dom_ok || dow_ok;
        endcase
        mo_ok  = month_mask_reg[mo_reg - 4'd1];
        mm_ge  = minute_mask_reg & ~((60'd1 << m_reg) - 60'd1);
        hm_gt  = hour_mask_reg & ~((24'd2 << h_reg) - 24'd1);
        h0_ok  = hour_mask_reg[h_reg] && (|mm_ge);
        hgt_ok = (|hm_gt) && (|minute_mask_reg);
        hit    = mo_ok && day_ok && (h0_ok || hgt_ok);
        hit_h  = h0_ok ? h_reg : cnms_pkg::first24(hm_gt);
        hit_m  = h0_ok ? cnms_pkg::first60(mm_ge) : cnms_pkg::first60(minute_mask_reg);
    end

    logic over;
    assign over = (yr_reg > maxy_reg) || yr_reg[cnms_pkg::YR_W-1];

    cnms_pkg::rsp_t rsp_next;
    always_comb begin
        rsp_next = '0;
        if (!over) begin
            rsp_next.found        = 1'b1;
            rsp_next.next_year    = yr_reg[11:0];
            rsp_next.next_month   = mo_reg;
            rsp_next.next_day     = d_reg;
            rsp_next.next_hour    = hit_h;
            rsp_next.next_minute  = hit_m;
            rsp_next.next_weekday = wd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            yr_reg <= in_yr;
            mo_reg <= in_mo;
            d_reg  <= in_d;
            h_reg  <= in_h;
            m_reg  <= in_m;
        end else if (cmd.adv) begin
            // one minute forward with carry, then fix the horizon
            logic [cnms_pkg::YR_W-1:0] ny;
            logic [3:0] nmo;
            logic [4:0] nd, nh;
            logic [5:0] nm;
            ny = yr_reg; nmo = mo_reg; nd = d_reg; nh = h_reg; nm = m_reg + 6'd1;
            if (nm > 6'd59) begin
                nm = 6'd0;
                nh = nh + 5'd1;
                if (nh > 5'd23) begin
                    nh = 5'd0;
                    if (nd >= cur_dim) begin
                        nd = 5'd1;
                        nmo = nmo + 4'd1;
                        if (nmo > 4'd12) begin
                            nmo = 4'd1;
                            ny = ny + cnms_pkg::YR_W'(1);
                        end
                    end else begin
                        nd = nd + 5'd1;
                    end
                end
            end
            yr_reg   <= ny;
            mo_reg   <= nmo;
            d_reg    <= nd;
            h_reg    <= nh;
            m_reg    <= nm;
            maxy_reg <= ny + cnms_pkg::YR_W'(cnms_pkg::SEARCH_YEARS);
        end else if (cmd.step) begin
            h_reg <= 5'd0;
            m_reg <= 6'd0;
            wd_reg <= (wd_reg == 3'd6) ? 3'd0 : wd_reg + 3'd1;
            if (d_reg >= cur_dim) begin
                d_reg <= 5'd1;
                if (mo_reg == 4'd12) begin
                    mo_reg <= 4'd1;
                    yr_reg <= yr_reg + cnms_pkg::YR_W'(1);
                end else begin
                    mo_reg <= mo_reg + 4'd1;
                end
            end else begin
                d_reg <= d_reg + 5'd1;
            end
        end
        if (cmd.wd1) begin
            logic [cnms_pkg::YR_W-1:0] yy;
            yy = yr_reg + cnms_pkg::YR_W'(400) - ((mo_reg < 4'd3) ? 13'd1 : 13'd0);
            yy_reg   <= yy;
            q100_reg <= cnms_pkg::div100(yy);
        end
        if (cmd.wd2) begin
            sum_reg <= yy_reg + {2'd0, yy_reg[12:2]} - {6'd0, q100_reg}
                     + {8'd0, q100_reg[6:2]} + {10'd0, cnms_pkg::SAK[mo_reg - 4'd1]}
                     + {8'd0, d_reg};
        end
        if (cmd.wd3) begin
            // sum mod 7 by reciprocal
            logic [28:0] p;
            logic [12:0] q7;
            p  = {16'd0, sum_reg} * 29'd9363;
            q7 = {3'd0, p[25:16]};
            wd_reg <= 3'(sum_reg - q7 * 13'd7);
        end
        if (cmd.out_load) begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.hit      = hit;
    assign sts.over     = over;
    assign sts.out_busy = m_valid_reg && !m_ready;
    assign m_valid      = m_valid_reg;
    assign m_rsp        = rsp_reg;

endmodule

// ----- hw/rtl/cnms_ctrl.sv -----
// cnms_ctrl: sequencer for setup, day-by-day search and result hand-off.
// Depends on cnms_pkg; commands cnms_dp through cnms_pkg::cmd_t.
module cnms_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cnms_pkg::sts_t sts,
    output cnms_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ADV  = 8'b0000_0010,
        ST_WD1  = 8'b0000_0100,
        ST_WD2  = 8'b0000_1000,
        ST_WD3  = 8'b0001_0000,
        ST_SRCH = 8'b0010_0000,
        ST_DONE = 8'b0100_0000,
        ST_SPARE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                cmd.adv    = 1'b1;
                state_next = ST_WD1;
            end
            ST_WD1: begin
                cmd.wd1    = 1'b1;
                state_next = ST_WD2;
            end
            ST_WD2: begin
                cmd.wd2    = 1'b1;
                state_next = ST_WD3;
            end
            ST_WD3: begin
                cmd.wd3    = 1'b1;
                state_next = ST_SRCH;
            end
            ST_SRCH: begin
                if (sts.over || sts.hit) state_next = ST_DONE;
                else                     cmd.step   = 1'b1;
            end
            ST_DONE: begin
                // hold until the result slot frees
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/cron_next_match_search.sv -----
// Sequence: setup (minute advance, weekday in three steps), a day-by-day search, and a
// result register that raises m_valid; at most about 2200 candidate days over the
// six-year horizon.
// Throughput: one request at a time; the next request is taken once the result is
// registered; a finished search holds while the previous result still waits on m_ready.
// Reset (aresetn low, synchronous): masks to all ones, limit flags to 0, sequencer idle.
module cron_next_match_search (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [2:0]                 cfg_index,
    input  logic [cnms_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  cnms_pkg::req_t             s_req,
    output logic                       m_valid,
    input  logic                       m_ready,
    output cnms_pkg::rsp_t             m_rsp
);

    cnms_pkg::cmd_t cmd;
    cnms_pkg::sts_t sts;

    cnms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cnms_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_req     (s_req),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_rsp     (m_rsp)
    );

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for cron_next_match_search (next cron firing minute).
// Depends on cnms_pkg and the cron_next_match_search RTL; needs no other files.
`timescale 1ns / 100ps

module tb_top;
    import cnms_pkg::*;

    localparam int LONG_HOLD = 12000;
    localparam int WATCHDOG  = 60000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [2:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    req_t              s_req;
    logic              m_valid;
    logic              m_ready;
    rsp_t              m_rsp;

    cron_next_match_search dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    // schedule copy held by the bench
    logic [59:0] sch_minute;
    logic [23:0] sch_hour;
    logic [30:0] sch_day;
    logic [11:0] sch_month;
    logic [6:0]  sch_weekday;
    logic        sch_day_lim;
    logic        sch_wday_lim;

    rsp_t pending_fires[$];
    int   errors;
    int   responses;
    int   not_found_cnt;
    int   quiet_cycles;
    bit   idle_enable;
    bit   hold_sink;
    bit   stim_done;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in(int y, int m);
        int tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) return 29;
        return tab[m - 1];
    endfunction

    function automatic int day_of_week(int y, int m, int d);
        int off[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
        int yy;
        yy = y + 400 - ((m < 3) ? 1 : 0);
        return (yy + yy / 4 - yy / 100 + yy / 400 + off[m - 1] + d) % 7;
    endfunction

    function automatic bit day_fires(int d, int wd);
        bit dom_ok;
        bit dow_ok;
        dom_ok = sch_day[d - 1];
        dow_ok = sch_weekday[wd];
        if (!sch_day_lim && !sch_wday_lim) return 1'b1;
        if (!sch_day_lim) return dow_ok;
        if (!sch_wday_lim) return dom_ok;
        return dom_ok || dow_ok;
    endfunction

    function automatic rsp_t next_fire(req_t r);
        rsp_t res;
        int y, mo, d, h0, m0, maxy, wd;
        res = '0;
        y  = r.start_year;
        mo = r.start_month;
        d  = r.start_day;
        h0 = r.start_hour;
        m0 = r.start_minute;
        if (mo < 1) mo = 1;
        if (mo > 12) mo = 12;
        if (d < 1) d = 1;
        if (d > days_in(y, mo)) d = days_in(y, mo);
        if (h0 > 23) h0 = 23;
        if (m0 > 59) m0 = 59;
        m0++;
        if (m0 > 59) begin
            m0 = 0;
            h0++;
            if (h0 > 23) begin
                h0 = 0;
                d++;
                if (d > days_in(y, mo)) begin
                    d = 1;
                    mo++;
                    if (mo > 12) begin
                        mo = 1;
                        y++;
                    end
                end
            end
        end
        maxy = y + SEARCH_YEARS;
        while (y <= maxy && y <= 4095) begin
            wd = day_of_week(y, mo, d);
            if (sch_month[mo - 1] && day_fires(d, wd)) begin
                for (int h = h0; h < 24; h++) begin
                    if (!sch_hour[h]) continue;
                    for (int m = (h == h0) ? m0 : 0; m < 60; m++) begin
                        if (sch_minute[m]) begin
                            res.found        = 1'b1;
                            res.next_year    = 12'(y);
                            res.next_month   = 4'(mo);
                            res.next_day     = 5'(d);
                            res.next_hour    = 5'(h);
                            res.next_minute  = 6'(m);
                            res.next_weekday = 3'(wd);
                            return res;
                        end
                    end
                end
            end
            h0 = 0;
            m0 = 0;
            d++;
            if (d > days_in(y, mo)) begin
                d = 1;
                mo++;
                if (mo > 12) begin
                    mo = 1;
                    y++;
                end
            end
        end
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MINUTE:   sch_minute   = val[59:0];
            REG_HOUR:     sch_hour     = val[23:0];
            REG_DAY:      sch_day      = val[30:0];
            REG_MONTH:    sch_month    = val[11:0];
            REG_WEEKDAY:  sch_weekday  = val[6:0];
            REG_DAY_LIM:  sch_day_lim  = val[0];
            REG_WDAY_LIM: sch_wday_lim = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // drop valid, then wait for every request to come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_fires.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // send one request; check row value if given, else use the predictor
    task automatic send_request(req_t r, bit use_row, rsp_t row);
        rsp_t exp;
        exp = next_fire(r);
        if (use_row && exp !== row) begin
            $display("%0t predictor row mismatch req=%h expected %h actual %h",
                     $time, r, row, exp);
            errors++;
        end
        while (idle_enable && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        pending_fires.insert(pending_fires.size(), use_row ? row : exp);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic req_t rand_request();
        req_t r;
        r.start_year   = 12'($urandom_range(1970, 2100));
        if ($urandom_range(9) == 0) r.start_year = 12'($urandom_range(0, 4095));
        r.start_month  = 4'($urandom_range(0, 15));
        r.start_day    = 5'($urandom_range(0, 31));
        r.start_hour   = 5'($urandom_range(0, 31));
        r.start_minute = 6'($urandom_range(0, 63));
        if ($urandom_range(3) != 0) begin
            r.start_month  = 4'($urandom_range(1, 12));
            r.start_hour   = 5'($urandom_range(0, 23));
            r.start_minute = 6'($urandom_range(0, 59));
        end
        return r;
    endfunction

    function automatic rsp_t fire(int y, int mo, int d, int h, int m, int wd);
        rsp_t r;
        r = '{1'b1, 12'(y), 4'(mo), 5'(d), 5'(h), 6'(m), 3'(wd)};
        return r;
    endfunction

    // result side: random stalls, one long hold-off, compare in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                responses++;
                if (!m_rsp.found) not_found_cnt++;
                if (pending_fires.size() == 0) begin
                    $display("%0t unexpected response %h", $time, m_rsp);
                    errors++;
                end else begin
                    rsp_t exp;
                    exp = pending_fires.pop_front();
                    if (m_rsp !== exp) begin
                        $display("%0t mismatch expected %h actual %h", $time, exp, m_rsp);
                        errors++;
                    end
                end
            end
            m_ready <= !hold_sink && !(idle_enable && $urandom_range(99) < 26);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("timeout, %0d requests outstanding", pending_fires.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    typedef struct {
        req_t r;
        bit   use_row;
        rsp_t row;
    } row_t;

    row_t stim_rows[$];

    task automatic add_row(req_t r, bit use_row, rsp_t row);
        row_t item;
        item.r       = r;
        item.use_row = use_row;
        item.row     = row;
        stim_rows.insert(stim_rows.size(), item);
    endtask

    initial begin
        req_t r;
        errors = 0; responses = 0; not_found_cnt = 0;
        idle_enable = 1'b0; hold_sink = 1'b0; stim_done = 1'b0;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_req = '0;
        sch_minute = '1; sch_hour = '1; sch_day = '1; sch_month = '1;
        sch_weekday = '1; sch_day_lim = 1'b0; sch_wday_lim = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset schedule fires every minute: next minute with carries
        add_row('{12'd2024, 4'd3, 5'd15, 5'd10, 6'd20}, 1'b1, fire(2024, 3, 15, 10, 21, 5));
        add_row('{12'd2023, 4'd12, 5'd31, 5'd23, 6'd59}, 1'b1, fire(2024, 1, 1, 0, 0, 1));
        add_row('{12'd2024, 4'd2, 5'd28, 5'd23, 6'd59}, 1'b1, fire(2024, 2, 29, 0, 0, 4));
        add_row('{12'd1900, 4'd2, 5'd28, 5'd23, 6'd59}, 1'b1, fire(1900, 3, 1, 0, 0, 4));
        add_row('{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0}, 1'b1, fire(1970, 1, 1, 0, 1, 4));
        // out of range month, day, hour, minute are clamped
        add_row('{12'd2023, 4'd0, 5'd0, 5'd31, 6'd63}, 1'b1, fire(2023, 1, 2, 0, 0, 1));
        add_row('{12'd2023, 4'd15, 5'd31, 5'd30, 6'd63}, 1'b1, fire(2024, 1, 1, 0, 0, 1));
        add_row('{12'd2023, 4'd4, 5'd31, 5'd10, 6'd0}, 1'b0, '0);
        // year 4095 end rolls over past the range: not found
        add_row('{12'd4095, 4'd12, 5'd31, 5'd23, 6'd59}, 1'b1, '0);
        add_row('{12'd4095, 4'd12, 5'd31, 5'd23, 6'd58}, 1'b1, fire(4095, 12, 31, 23, 59, 6));
        add_row('{12'd0, 4'd1, 5'd1, 5'd0, 6'd0}, 1'b0, '0);
        foreach (stim_rows[i])
            send_request(stim_rows[i].r, stim_rows[i].use_row, stim_rows[i].row);
        wait_drained();

        // yearly at Feb 29 noon: leap day search across a century
        write_reg(REG_MINUTE, 60'd1);
        write_reg(REG_HOUR, 60'(1 << 12));
        write_reg(REG_MONTH, 60'd2);
        write_reg(REG_DAY, 60'(1 << 28));
        write_reg(REG_DAY_LIM, 60'd1);
        send_request('{12'd2097, 4'd3, 5'd1, 5'd0, 6'd0}, 1, '0);
        send_request('{12'd2095, 4'd3, 5'd1, 5'd0, 6'd0}, 0, '0);
        send_request('{12'd2024, 4'd2, 5'd29, 5'd12, 6'd0}, 0, '0);
        wait_drained();
        // both day fields limited; extremes of the masks
        write_reg(REG_MINUTE, {1'b1, 59'd0} | 60'hFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MINUTE, 60'(1) << 59);
        write_reg(REG_HOUR, 60'(1) << 23);
        write_reg(REG_MONTH, 60'h800);
        write_reg(REG_DAY, 60'(1) << 30);
        write_reg(REG_WEEKDAY, 60'd1);
        write_reg(REG_WDAY_LIM, 60'd1);
        send_request('{12'd2023, 4'd6, 5'd5, 5'd1, 6'd2}, 0, '0);
        wait_drained();
        write_reg(REG_DAY_LIM, 60'd0);
        send_request('{12'd2023, 4'd12, 5'd3, 5'd23, 6'd59}, 0, '0);
        wait_drained();
        write_reg(REG_HOUR, 60'd0);
        send_request('{12'd2023, 4'd6, 5'd5, 5'd1, 6'd2}, 1, '0);
        wait_drained();
        write_reg(3'd7, '1);

        // random phases with random schedules
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_MINUTE, ($urandom_range(3) == 0) ? '1 :
                      60'({$urandom(), $urandom()} & ~({$urandom(), $urandom()})));
            write_reg(REG_HOUR, ($urandom_range(2) == 0) ? '1 : 60'($urandom()));
            write_reg(REG_DAY, ($urandom_range(2) == 0) ? '1 : 60'($urandom()));
            write_reg(REG_MONTH, ($urandom_range(2) == 0) ? '1 : 60'($urandom()));
            write_reg(REG_WEEKDAY, 60'($urandom()));
            write_reg(REG_DAY_LIM, 60'($urandom()));
            write_reg(REG_WDAY_LIM, 60'($urandom()));
            idle_enable = (ph != 2);
            if (ph == 4) begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (LONG_HOLD) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 17; i++) begin
                r = rand_request();
                send_request(r, 0, '0);
            end
            wait_drained();
        end
        stim_done = 1'b1;
        wait_drained();
        $display("ran %0d requests over directed and random schedules, %0d not found",
                 responses, not_found_cnt);
        $display("covered clamped inputs, leap years, the year range end and a long stall");
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/cnms_pkg.sv
hw/rtl/cnms_dp.sv
hw/rtl/cnms_ctrl.sv
hw/rtl/cron_next_match_search.sv
sim/tb_top.sv
